@@ rtl/core/bsld_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, codes and controller/datapath bundles for the line-graph distance search.
package bsld_pkg;

  localparam int MAX_NODES = 1024;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int CNT_W     = NODE_W + 1;
  localparam int OP_W      = 2;
  localparam int DATA_W    = 32;
  localparam int PADDR_W   = 3;

  localparam logic [CNT_W-1:0] NODE_COUNT_RST = CNT_W'(MAX_NODES);
  localparam logic [0:0]       REG_NODE_COUNT = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD = 2'd0,
    OP_RUN  = 2'd1,
    OP_READ = 2'd2
  } op_e;

  // Neighbor being examined for the node at the head of the search.
  typedef enum logic [1:0] {
    CAND_LEFT  = 2'd0,
    CAND_RIGHT = 2'd1,
    CAND_SHORT = 2'd2
  } cand_e;

  typedef struct packed {
    logic  take;
    logic  sc_write;
    logic  clr_step;
    logic  seed;
    logic  q_read;
    logic  node_load;
    logic  vis_read;
    cand_e vis_sel;
    logic  check;
    cand_e check_sel;
    logic  dist_read;
    logic  out_load;
  } bsld_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic q_nonempty;
    logic push;
    logic out_free;
  } bsld_sts_t;

endpackage

@@ rtl/core/bsld_if.sv @@
`timescale 1ns / 1ps
// Request and result channel interfaces with valid/ready handshake.
interface bsld_in_if
  import bsld_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [NODE_W-1:0]   node_index;
  logic [CNT_W-1:0]    shortcut_target;

  modport source (output valid, operation, node_index, shortcut_target, input ready);
  modport sink   (input valid, operation, node_index, shortcut_target, output ready);
endinterface

interface bsld_out_if
  import bsld_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [NODE_W-1:0] result_node;
  logic [NODE_W-1:0] distance;

  modport source (output valid, result_node, distance, input ready);
  modport sink   (input valid, result_node, distance, output ready);
endinterface

@@ rtl/core/bsld_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer that walks the breadth-first search and the load and read requests.
module bsld_ctrl import bsld_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [OP_W-1:0] in_op_i,
  output logic            in_ready_o,
  input  bsld_sts_t       sts_i,
  output bsld_cmd_t       cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SC_WRITE,
    S_CLEAR,
    S_SEED,
    S_POP,
    S_LOAD,
    S_VR0,
    S_VR1,
    S_VR2,
    S_VFIN,
    S_DIST_RD,
    S_RESP
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          unique case (in_op_i)
            OP_LOAD: state_d = S_SC_WRITE;
            OP_RUN:  state_d = S_CLEAR;
            OP_READ: state_d = S_DIST_RD;
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_SC_WRITE: begin
        cmd_o.sc_write = 1'b1;
        state_d        = S_IDLE;
      end
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_SEED;
        end
      end
      S_SEED: begin
        cmd_o.seed = 1'b1;
        state_d    = S_POP;
      end
      S_POP: begin
        cmd_o.q_read = 1'b1;
        state_d      = S_LOAD;
      end
      S_LOAD: begin
        cmd_o.node_load = 1'b1;
        state_d         = S_VR0;
      end
      S_VR0: begin
        cmd_o.vis_read = 1'b1;
        cmd_o.vis_sel  = CAND_LEFT;
        state_d        = S_VR1;
      end
      S_VR1: begin
        cmd_o.check     = 1'b1;
        cmd_o.check_sel = CAND_LEFT;
        cmd_o.vis_read  = 1'b1;
        cmd_o.vis_sel   = CAND_RIGHT;
        state_d         = S_VR2;
      end
      S_VR2: begin
        cmd_o.check     = 1'b1;
        cmd_o.check_sel = CAND_RIGHT;
        cmd_o.vis_read  = 1'b1;
        cmd_o.vis_sel   = CAND_SHORT;
        state_d         = S_VFIN;
      end
      S_VFIN: begin
        cmd_o.check     = 1'b1;
        cmd_o.check_sel = CAND_SHORT;
        // The head entry can be fetched now unless it is the one being pushed.
        if (sts_i.q_nonempty) begin
          cmd_o.q_read = 1'b1;
          state_d      = S_LOAD;
        end else if (sts_i.push) begin
          state_d = S_POP;
        end else begin
          state_d = S_DIST_RD;
        end
      end
      S_DIST_RD: begin
        cmd_o.dist_read = 1'b1;
        state_d         = S_RESP;
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/core/bsld_dp.sv @@
`timescale 1ns / 1ps
// Datapath: shortcut, distance, visited and queue memories, pointers and result register.
module bsld_dp import bsld_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bsld_cmd_t         cmd_i,
  output bsld_sts_t         sts_o,
  input  logic [CNT_W-1:0]  node_n_i,
  input  logic [OP_W-1:0]   in_op_i,
  input  logic [NODE_W-1:0] in_index_i,
  input  logic [CNT_W-1:0]  in_target_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [NODE_W-1:0] out_node_o,
  output logic [NODE_W-1:0] out_dist_o
);

  localparam int QE_W = 2 * NODE_W;

  logic [CNT_W-1:0]  sc_mem   [MAX_NODES];
  logic [NODE_W-1:0] dist_mem [MAX_NODES];
  logic              vis_mem  [MAX_NODES];
  logic [QE_W-1:0]   q_mem    [MAX_NODES];

  logic [OP_W-1:0]   op_q;
  logic [NODE_W-1:0] idx_q;
  logic [CNT_W-1:0]  tgt_q;
  logic [NODE_W-1:0] clr_cnt_q;
  logic [CNT_W-1:0]  head_q, tail_q;
  logic [NODE_W-1:0] cur_node_q, cur_dist_q;
  logic [CNT_W-1:0]  sc_rd_q;
  logic              vis_rd_q;
  logic [NODE_W-1:0] dist_rd_q;
  logic [QE_W-1:0]   q_rd_q;
  logic              out_valid_q;
  logic [NODE_W-1:0] out_node_q, out_dist_q;

  logic [CNT_W-1:0]  next_node;
  logic [NODE_W-1:0] last_node;
  logic [NODE_W-1:0] dist_inc;
  logic              left_ok, right_ok, short_ok;
  logic [NODE_W-1:0] left_addr, right_addr, short_addr;
  logic [NODE_W-1:0] chk_addr, rd_addr;
  logic              chk_ok, push;

  logic              vis_we, vis_wd;
  logic [NODE_W-1:0] vis_wa;
  logic              dist_we;
  logic [NODE_W-1:0] dist_wa, dist_wd, dist_ra;
  logic              q_we;
  logic [NODE_W-1:0] q_wa;
  logic [QE_W-1:0]   q_wd;

  // Neighbors of the current node and whether each one exists in the active graph.
  assign next_node  = {1'b0, cur_node_q} + CNT_W'(1);
  assign last_node  = NODE_W'(node_n_i - CNT_W'(1));
  assign dist_inc   = cur_dist_q + NODE_W'(1);
  assign left_ok    = (cur_node_q != '0);
  assign right_ok   = (next_node < node_n_i);
  // A shortcut equal to the right neighbor is skipped: that node is reached anyway at the
  // same depth, and its visited write would still be in flight when the shortcut is read.
  assign short_ok   = right_ok && (sc_rd_q < node_n_i) && (sc_rd_q != {1'b0, cur_node_q})
                      && (sc_rd_q != next_node);
  assign left_addr  = cur_node_q - NODE_W'(1);
  assign right_addr = next_node[NODE_W-1:0];
  assign short_addr = sc_rd_q[NODE_W-1:0];

  always_comb begin
    case (cmd_i.check_sel)
      CAND_LEFT: begin
        chk_addr = left_addr;
        chk_ok   = left_ok;
      end
      CAND_RIGHT: begin
        chk_addr = right_addr;
        chk_ok   = right_ok;
      end
      CAND_SHORT: begin
        chk_addr = short_addr;
        chk_ok   = short_ok;
      end
      default: begin
        chk_addr = left_addr;
        chk_ok   = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (cmd_i.vis_sel)
      CAND_LEFT:  rd_addr = left_addr;
      CAND_RIGHT: rd_addr = right_addr;
      CAND_SHORT: rd_addr = short_addr;
      default:    rd_addr = left_addr;
    endcase
  end

  assign push = cmd_i.check && chk_ok && !vis_rd_q;

  assign sts_o.clr_last   = ({1'b0, clr_cnt_q} == (node_n_i - CNT_W'(1)));
  assign sts_o.q_nonempty = (head_q != tail_q);
  assign sts_o.push       = push;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  // Write port selection.
  assign vis_we  = cmd_i.clr_step || cmd_i.seed || push;
  assign vis_wa  = cmd_i.clr_step ? clr_cnt_q : (cmd_i.seed ? '0 : chk_addr);
  assign vis_wd  = !cmd_i.clr_step;
  assign dist_we = cmd_i.seed || push;
  assign dist_wa = cmd_i.seed ? '0 : chk_addr;
  assign dist_wd = cmd_i.seed ? '0 : dist_inc;
  assign dist_ra = (op_q == OP_RUN) ? last_node : idx_q;
  assign q_we    = cmd_i.seed || push;
  assign q_wa    = cmd_i.seed ? '0 : tail_q[NODE_W-1:0];
  assign q_wd    = cmd_i.seed ? '0 : {chk_addr, dist_inc};

  always_ff @(posedge clk_i) begin
    if (cmd_i.sc_write && (tgt_q != '0)) begin
      sc_mem[idx_q] <= tgt_q - CNT_W'(1);
    end
    if (cmd_i.node_load) begin
      sc_rd_q <= sc_mem[q_rd_q[QE_W-1:NODE_W]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (vis_we) begin
      vis_mem[vis_wa] <= vis_wd;
    end
    if (cmd_i.vis_read) begin
      vis_rd_q <= vis_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dist_we) begin
      dist_mem[dist_wa] <= dist_wd;
    end
    if (cmd_i.dist_read) begin
      dist_rd_q <= dist_mem[dist_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_we) begin
      q_mem[q_wa] <= q_wd;
    end
    if (cmd_i.q_read) begin
      q_rd_q <= q_mem[head_q[NODE_W-1:0]];
    end
  end

  // Request fields, the node under examination and the result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      op_q  <= in_op_i;
      idx_q <= in_index_i;
      tgt_q <= in_target_i;
    end
    if (cmd_i.node_load) begin
      cur_node_q <= q_rd_q[QE_W-1:NODE_W];
      cur_dist_q <= q_rd_q[NODE_W-1:0];
    end
    if (cmd_i.out_load) begin
      out_node_q <= (op_q == OP_RUN) ? last_node : idx_q;
      out_dist_q <= dist_rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.take) begin
        clr_cnt_q <= '0;
      end else if (cmd_i.clr_step) begin
        clr_cnt_q <= clr_cnt_q + NODE_W'(1);
      end
      if (cmd_i.seed) begin
        head_q <= '0;
        tail_q <= CNT_W'(1);
      end else begin
        if (cmd_i.q_read) begin
          head_q <= head_q + CNT_W'(1);
        end
        if (push) begin
          tail_q <= tail_q + CNT_W'(1);
        end
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_node_o  = out_node_q;
  assign out_dist_o  = out_dist_q;

endmodule

@@ rtl/core/bfs_shortcut_line_distance.sv @@
`timescale 1ns / 1ps
// Top level of the hop-distance search over a line graph with one-way shortcuts.
//
// Requests arrive on req_i and results leave on rsp_o; both use a valid/ready handshake.
// A load request stores one node's shortcut and gives no result; a run request searches
// from node 0 and returns the distance of the last node; a read request returns one
// stored distance. An unused operation code is taken and dropped.
// The node count register sits on the APB-style port at byte address 0. The user must
// see that it is written only while the block is idle; the block does not enforce it.
// The block handles one request at a time. A load passes through its shortcut write step
// and goes back to idle; a read fetches the stored distance, then loads the output register.
// A run first clears the visited memory one entry per cycle for the N active nodes, then
// takes each dequeued node in turn, using the single read port of the visited memory to
// check its left, right and shortcut neighbors one after another.
// Reset returns the node count to 1024, empties the queue and idles the controller; the
// shortcut and distance memories keep no reset value.
// A result waits in the output register while the receiver stalls; the next request is
// still accepted, and its result is held back until the register frees up.
module bfs_shortcut_line_distance import bsld_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  bsld_in_if.sink            req_i,
  bsld_out_if.source         rsp_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  logic [CNT_W-1:0] node_count_q;
  logic [CNT_W-1:0] node_n;
  logic             reg_hit;
  logic             in_ready;
  bsld_cmd_t        cmd;
  bsld_sts_t        sts;

  // Configuration register. Word index is taken from the address above the byte offset.
  assign pready  = 1'b1;
  assign reg_hit = (paddr[PADDR_W-1:2] == REG_NODE_COUNT);
  assign prdata  = reg_hit ? DATA_W'(node_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NODE_COUNT_RST;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      node_count_q <= pwdata[CNT_W-1:0];
    end
  end

  // Active node count: zero behaves as one node, values above the memory depth saturate.
  always_comb begin
    if (node_count_q == '0) begin
      node_n = CNT_W'(1);
    end else if (node_count_q > CNT_W'(MAX_NODES)) begin
      node_n = CNT_W'(MAX_NODES);
    end else begin
      node_n = node_count_q;
    end
  end

  assign req_i.ready = in_ready;

  bsld_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_op_i    (req_i.operation),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bsld_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .node_n_i    (node_n),
    .in_op_i     (req_i.operation),
    .in_index_i  (req_i.node_index),
    .in_target_i (req_i.shortcut_target),
    .out_ready_i (rsp_o.ready),
    .out_valid_o (rsp_o.valid),
    .out_node_o  (rsp_o.result_node),
    .out_dist_o  (rsp_o.distance)
  );

endmodule
